### design/assert_macros.svh
// Assertion macros shared by the rasteriser RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, quiet while reset is applied.
`define ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### design/tftr_pkg.sv
// Types and constants for the 3x5 font column rasteriser.
// No dependencies.
package tftr_pkg;

	// Request codes carried by req_type
	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_START  = 2'd1,
		REQ_RENDER = 2'd2
	} req_type_t;

	// Configuration register indexes
	typedef enum logic {
		CFG_ROW_OFFSET  = 1'b0,
		CFG_FIXED_WIDTH = 1'b1
	} cfg_index_t;

	localparam logic [7:0] CODE_LOW   = 8'h1e;
	localparam logic [7:0] CODE_HIGH  = 8'h7f;
	localparam logic [6:0] CURSOR_MAX = 7'd63;

endpackage

### design/tiny_font_text_rasterizer_unit.sv
// Top level of the 3x5 font column rasteriser: glyph memory, cursor logic, column queue.
// Depends on tftr_pkg and assert_macros.svh.
//
//   channel   direction  handshake            payload
//   in        to block   in_valid/in_stall    req_type glyph_slot glyph_word char_code start_column
//   out       from block out_valid/out_stall  column_index column_bits last_column
//   cfg       to block   cfg_we               cfg_index cfg_data
//
// Loads, starts and renders that place nothing put nothing in the column queue; a render that
// emits k columns loads k queue entries, sent one column per cycle on the out channel while
// out_stall is low. A result passes the glyph memory read register, then column decode
// into the queue. Reset (arst_n) clears the cursor, sets the end-of-string flag and clears
// the configuration, decode-valid and queue-count registers; the glyph memory keeps no reset
// value. A stall on out holds the queue and, once the decode stage is blocked, raises in_stall.
`include "assert_macros.svh"

module tiny_font_text_rasterizer_unit
	import tftr_pkg::*;
#(
	parameter int DISPLAY_WIDTH = 48,
	parameter int GLYPH_COUNT   = 98
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [2:0]  cfg_data,
	// request items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [6:0]  glyph_slot,
	input  logic [15:0] glyph_word,
	input  logic [7:0]  char_code,
	input  logic [5:0]  start_column,
	// column items
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  column_index,
	output logic [7:0]  column_bits,
	output logic        last_column
);

	localparam int         ADDR_W   = $clog2(GLYPH_COUNT);
	localparam logic [7:0] GC8      = 8'(GLYPH_COUNT);
	localparam logic [6:0] LAST_SLOT = 7'(GLYPH_COUNT - 1);
	localparam logic [6:0] DW7      = 7'(DISPLAY_WIDTH);
	localparam logic [6:0] LIMIT7   = 7'(DISPLAY_WIDTH + 3);

	// registers and state
	logic [2:0]  row_offset_q;
	logic        fixed_width_q;
	logic [5:0]  cursor_q;
	logic        ended_q;

	logic [15:0] glyph_mem [GLYPH_COUNT];

	logic        s1_valid_q;
	logic [1:0]  req_type_s1;
	logic        code_zero_s1;
	logic [5:0]  start_s1;
	logic [15:0] word_s1;

	logic [7:0]  e_bits_q [3];
	logic [5:0]  e_idx_q  [3];
	logic        e_last_q [3];
	logic [1:0]  e_cnt_q;

	logic        in_accept;
	logic        out_accept;
	logic        s1_adv;
	logic        rend_go;
	logic        load_new;
	logic        in_range;
	logic [7:0]  code_eff;
	logic [6:0]  slot7;
	logic [6:0]  slot_sat;
	logic [ADDR_W-1:0] rd_addr;

	logic        desc;
	logic [7:0]  col [3];
	logic        plc [3];
	logic [1:0]  n_placed;
	logic [6:0]  pos;
	logic [7:0]  nq_bits [3];
	logic [5:0]  nq_idx  [3];
	logic        nq_last [3];
	logic [1:0]  nq_cnt;
	logic [6:0]  cur_sum;
	logic [5:0]  cur_next;

	// handshake
	assign out_accept = out_valid && !out_stall;
	assign s1_adv     = s1_valid_q && ((e_cnt_q == 2'd0) || (e_cnt_q == 2'd1 && out_accept));
	assign in_stall   = s1_valid_q && !s1_adv;
	assign in_accept  = in_valid && !in_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_offset_q  <= '0;
			fixed_width_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROW_OFFSET:  row_offset_q  <= cfg_data;
				CFG_FIXED_WIDTH: fixed_width_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// map the character code onto a glyph slot, last glyph for anything out of range
	always_comb begin
		in_range = (char_code >= CODE_LOW) && (char_code <= CODE_HIGH);
		code_eff = in_range ? char_code : CODE_HIGH;
		slot7    = 7'(code_eff - CODE_LOW);
		slot_sat = ({1'b0, slot7} >= GC8) ? LAST_SLOT : slot7;
		rd_addr  = slot_sat[ADDR_W-1:0];
	end

	// glyph memory: write on load, registered read on every accepted item
	always_ff @(posedge clk) begin
		if (in_accept && req_type == REQ_LOAD && {1'b0, glyph_slot} < GC8) begin
			glyph_mem[glyph_slot[ADDR_W-1:0]] <= glyph_word;
		end
		if (in_accept) begin
			word_s1 <= glyph_mem[rd_addr];
		end
	end

	// decode stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// decode stage payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_type_s1  <= req_type;
			code_zero_s1 <= (char_code == 8'd0);
			start_s1     <= start_column;
		end
	end

	// build glyph columns, pick the placed ones and pack the onscreen ones
	always_comb begin
		desc   = word_s1[0];
		col[0] = {3'b000, word_s1[15:11]} << desc;
		col[1] = {3'b000, word_s1[10:6]}  << desc;
		col[2] = {3'b000, word_s1[5:1]}   << desc;
		plc[0] = fixed_width_q || (col[0] != 8'd0);
		plc[1] = fixed_width_q || (col[1] != 8'd0) || ((col[0] != 8'd0) && (col[2] != 8'd0));
		plc[2] = fixed_width_q || (col[2] != 8'd0);
		n_placed = '0;
		nq_cnt   = '0;
		pos      = '0;
		for (int k = 0; k < 3; k++) begin
			nq_bits[k] = '0;
			nq_idx[k]  = '0;
		end
		for (int k = 0; k < 3; k++) begin
			if (plc[k]) begin
				pos = {1'b0, cursor_q} + {5'd0, n_placed};
				if (pos < DW7) begin
					nq_bits[nq_cnt] = col[k] << row_offset_q;
					nq_idx[nq_cnt]  = pos[5:0];
					nq_cnt          = nq_cnt + 2'd1;
				end
				n_placed = n_placed + 2'd1;
			end
		end
		for (int k = 0; k < 3; k++) begin
			nq_last[k] = (nq_cnt != 2'd0) && (2'(k) == nq_cnt - 2'd1);
		end
		cur_sum  = {1'b0, cursor_q} + {5'd0, n_placed} + 7'd1;
		cur_next = (cur_sum > CURSOR_MAX) ? 6'd63 : cur_sum[5:0];
	end

	assign rend_go  = s1_adv && req_type_s1 == REQ_RENDER && !ended_q
		&& ({1'b0, cursor_q} < LIMIT7) && !code_zero_s1;
	assign load_new = rend_go && (nq_cnt != 2'd0);

	// cursor and end-of-string flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			ended_q  <= 1'b1;
		end else if (s1_adv) begin
			if (req_type_s1 == REQ_START) begin
				cursor_q <= start_s1;
				ended_q  <= 1'b0;
			end else if (req_type_s1 == REQ_RENDER && !ended_q
					&& ({1'b0, cursor_q} < LIMIT7)) begin
				if (code_zero_s1) begin
					ended_q <= 1'b1;
				end else begin
					cursor_q <= cur_next;
				end
			end
		end
	end

	// column queue count: reload with a new glyph or drop the head on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_cnt_q <= '0;
		end else if (load_new) begin
			e_cnt_q <= nq_cnt;
		end else if (out_accept) begin
			e_cnt_q <= e_cnt_q - 2'd1;
		end
	end

	// column queue payload: load a new glyph's columns or advance entries towards the head
	always_ff @(posedge clk) begin
		if (load_new) begin
			for (int k = 0; k < 3; k++) begin
				e_bits_q[k] <= nq_bits[k];
				e_idx_q[k]  <= nq_idx[k];
				e_last_q[k] <= nq_last[k];
			end
		end else if (out_accept) begin
			for (int k = 0; k < 2; k++) begin
				e_bits_q[k] <= e_bits_q[k+1];
				e_idx_q[k]  <= e_idx_q[k+1];
				e_last_q[k] <= e_last_q[k+1];
			end
		end
	end

	assign out_valid    = (e_cnt_q != 2'd0);
	assign column_index = e_idx_q[0];
	assign column_bits  = e_bits_q[0];
	assign last_column  = e_last_q[0];

	`ASSERT_IMPL(a_stall_needs_s1, in_stall, s1_valid_q, "input stalled with decode stage empty")
	`ASSERT_IMPL(a_reload_when_free, load_new,
		(e_cnt_q == 2'd0) || (e_cnt_q == 2'd1 && out_accept),
		"column queue reloaded while still holding columns")
	`ASSERT_IMPL(a_last_at_tail, out_valid, last_column == (e_cnt_q == 2'd1),
		"last_column out of step with queue fill")
	`ASSERT_NEXT(a_queue_keeps_valid, out_valid && e_cnt_q != 2'd1, out_valid,
		"column queue emptied before its last column")
	`ASSERT_IMPL(a_index_onscreen, out_valid, {1'b0, column_index} < DW7,
		"column index beyond display width")

endmodule
